@@ hdl/slfe_pkg.sv @@
// Shared types, constants and the CRC-16/XMODEM byte update for the SLIP frame encoder.
`timescale 1ns / 1ps

package slfe_pkg;

    localparam logic [7:0] END_CHAR    = 8'd192;
    localparam logic [7:0] ESC_CHAR    = 8'd219;
    localparam logic [7:0] ESC_END     = 8'd220;
    localparam logic [7:0] ESC_ESC     = 8'd221;
    localparam logic [7:0] MARK_FIRST  = 8'hF0;
    localparam logic [7:0] MARK_SECOND = 8'hE0;
    localparam logic [15:0] CRC_INIT   = 16'h0000;
    localparam logic [1:0] POS_SAT     = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
    } out_item_t;

    // One classified item handed from the front to the back.
    typedef struct packed {
        logic        open_frame;
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc;
    } job_t;

    typedef enum logic [2:0] {
        PH_OPEN,
        PH_DATA,
        PH_CRC_HI,
        PH_CRC_LO,
        PH_CLOSE
    } phase_t;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] x;
        x = crc[15:8] ^ b;
        x = x ^ {4'h0, x[7:4]};
        return {crc[7:0], 8'h00} ^ {x[3:0], 12'h000} ^ {3'b000, x, 5'b00000} ^ {8'h00, x};
    endfunction

endpackage

@@ hdl/slip_frame_encoder_crc16.sv @@
// Top level of the SLIP frame encoder with CRC-16/XMODEM trailer.
//
//   channel   handshake                 carries
//   input     push / full               item   : data_byte, last_byte
//   result    pop / empty               result : out_byte, run_last, frame_end
//   config    cfg_valid / cfg_ready     cfg_data : header_mark_enable
//
// The front builds a job combinationally and hands it to a two-entry queue; it takes a
// new item every cycle while the queue has room. The back emits one frame byte per cycle
// while the output is free or popped: an item gives 1 to 8 result bytes, usually 1 or 2.
// Reset clears packet state, the queue and the output valid flag; header marking resets on.
// A stalled result holds in the output register while the front keeps filling the queue.
`timescale 1ns / 1ps

module slip_frame_encoder_crc16
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  slfe_pkg::in_item_t  item,
    output logic                empty,
    input  logic                pop,
    output slfe_pkg::out_item_t result,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data
);

    logic           job_push;
    logic           job_full;
    logic           job_pop;
    logic           job_valid;
    slfe_pkg::job_t job_in;
    slfe_pkg::job_t job_out;

    assign cfg_ready = 1'b1;
    assign full      = job_full;

    slfe_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item     (item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .job_full (job_full),
        .job_push (job_push),
        .job      (job_in)
    );

    slfe_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (job_push),
        .wr_job   (job_in),
        .full     (job_full),
        .rd       (job_pop),
        .nonempty (job_valid),
        .rd_job   (job_out)
    );

    slfe_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job_out),
        .job_pop   (job_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

@@ hdl/slfe_front.sv @@
// Front end: takes input items, applies header marks, folds the CRC and builds jobs.
`timescale 1ns / 1ps

module slfe_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  slfe_pkg::in_item_t item,
    input  logic              cfg_we,
    input  logic              cfg_data,
    input  logic              job_full,
    output logic              job_push,
    output slfe_pkg::job_t    job
);

    logic        mark_en_reg;
    logic        in_packet_reg;
    logic        in_packet_next;
    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [1:0]  pos_cur;
    logic [15:0] crc_cur;
    logic [7:0]  marked;
    logic [15:0] crc_new;

    assign job_push = push && !job_full;

    always_comb
    begin
        pos_cur = in_packet_reg ? pos_reg : 2'd0;
        crc_cur = in_packet_reg ? crc_reg : slfe_pkg::CRC_INIT;
        marked  = item.data_byte;
        if (mark_en_reg)
        begin
            if (pos_cur == 2'd0)
            begin
                marked = item.data_byte | slfe_pkg::MARK_FIRST;
            end
            else if (pos_cur == 2'd1)
            begin
                marked = item.data_byte | slfe_pkg::MARK_SECOND;
            end
        end
        crc_new = slfe_pkg::crc_update(crc_cur, marked);

        job.open_frame = !in_packet_reg;
        job.data       = marked;
        job.last       = item.last_byte;
        job.crc        = crc_new;

        in_packet_next = in_packet_reg;
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        if (job_push)
        begin
            if (item.last_byte)
            begin
                // drop back to awaiting an opening byte
                in_packet_next = 1'b0;
                pos_next       = 2'd0;
                crc_next       = slfe_pkg::CRC_INIT;
            end
            else
            begin
                in_packet_next = 1'b1;
                pos_next       = (pos_cur == slfe_pkg::POS_SAT) ? pos_cur : pos_cur + 2'd1;
                crc_next       = crc_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_en_reg   <= 1'b1;
            in_packet_reg <= 1'b0;
            pos_reg       <= 2'd0;
            crc_reg       <= slfe_pkg::CRC_INIT;
        end
        else
        begin
            if (cfg_we)
            begin
                mark_en_reg <= cfg_data;
            end
            in_packet_reg <= in_packet_next;
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
        end
    end

endmodule

@@ hdl/slfe_queue.sv @@
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps

module slfe_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  slfe_pkg::job_t wr_job,
    output logic           full,
    input  logic           rd,
    output logic           nonempty,
    output slfe_pkg::job_t rd_job
);

    slfe_pkg::job_t mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign nonempty = (count_reg != 2'd0);
    assign rd_job   = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr && !rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (rd)
            begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

@@ hdl/slfe_back.sv @@
// Back end: escapes each job into frame bytes, one per cycle unless the output register stalls.
`timescale 1ns / 1ps

module slfe_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  slfe_pkg::job_t    job,
    output logic              job_pop,
    output logic              empty,
    input  logic              pop,
    output slfe_pkg::out_item_t result
);

    slfe_pkg::phase_t phase_reg;
    slfe_pkg::phase_t phase_next;
    slfe_pkg::phase_t phase_cur;
    logic       esc_reg;
    logic       esc_next;
    logic       out_valid_reg;
    slfe_pkg::out_item_t out_reg;
    logic       load;
    logic [7:0] src;
    logic       needs_esc;
    logic       byte_done;
    logic       finish;
    slfe_pkg::out_item_t emit;

    assign empty  = !out_valid_reg;
    assign result = out_reg;
    assign load   = job_valid && (!out_valid_reg || pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= slfe_pkg::PH_OPEN;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= emit;
        end
    end

    always_comb
    begin
        // skip the opening END when the packet is already open
        phase_cur = phase_reg;
        if (phase_reg == slfe_pkg::PH_OPEN && !job.open_frame)
        begin
            phase_cur = slfe_pkg::PH_DATA;
        end

        case (phase_cur)
            slfe_pkg::PH_DATA:   src = job.data;
            slfe_pkg::PH_CRC_HI: src = job.crc[15:8];
            slfe_pkg::PH_CRC_LO: src = job.crc[7:0];
            default:             src = slfe_pkg::END_CHAR;
        endcase

        needs_esc = (phase_cur inside {slfe_pkg::PH_DATA, slfe_pkg::PH_CRC_HI,
                                       slfe_pkg::PH_CRC_LO})
                    && (src == slfe_pkg::END_CHAR || src == slfe_pkg::ESC_CHAR);

        emit.frame_end = (phase_cur == slfe_pkg::PH_CLOSE);
        if (esc_reg)
        begin
            emit.out_byte = (src == slfe_pkg::END_CHAR) ? slfe_pkg::ESC_END : slfe_pkg::ESC_ESC;
            byte_done     = 1'b1;
        end
        else if (needs_esc)
        begin
            emit.out_byte = slfe_pkg::ESC_CHAR;
            byte_done     = 1'b0;
        end
        else
        begin
            emit.out_byte = src;
            byte_done     = 1'b1;
        end

        finish = 1'b0;
        phase_next = phase_reg;
        case (phase_cur)
            slfe_pkg::PH_OPEN:   phase_next = slfe_pkg::PH_DATA;
            slfe_pkg::PH_DATA:
            begin
                if (job.last)
                begin
                    phase_next = slfe_pkg::PH_CRC_HI;
                end
                else
                begin
                    finish = 1'b1;
                end
            end
            slfe_pkg::PH_CRC_HI: phase_next = slfe_pkg::PH_CRC_LO;
            slfe_pkg::PH_CRC_LO: phase_next = slfe_pkg::PH_CLOSE;
            slfe_pkg::PH_CLOSE:  finish = 1'b1;
            default:             finish = 1'b1;
        endcase
        finish = finish && byte_done;
        if (finish)
        begin
            phase_next = slfe_pkg::PH_OPEN;
        end
        emit.run_last = finish;

        // hold everything unless a byte actually moves into the output register
        esc_next = esc_reg;
        job_pop  = 1'b0;
        if (load)
        begin
            esc_next = !byte_done;
            job_pop  = finish;
            if (!byte_done)
            begin
                phase_next = phase_reg;
            end
        end
        else
        begin
            phase_next = phase_reg;
        end
    end

endmodule

@@ test/slip_frame_encoder_crc16_test.sv @@
// Self-checking testbench for the SLIP frame encoder with CRC-16/XMODEM trailer.
`timescale 1ns / 1ps

module slip_frame_encoder_crc16_test;

    import slfe_pkg::*;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      push      = 1'b0;
    logic      full;
    in_item_t  item      = '0;
    logic      empty;
    logic      pop       = 1'b0;
    out_item_t result;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data  = 1'b0;

    // Items waiting to be offered, and frame bytes the encoder still owes us
    in_item_t  tx_items[$];
    out_item_t enc_due[$];

    // Predictor state
    logic        mark_en  = 1'b1;
    logic        pkt_open = 1'b0;
    logic [1:0]  byte_pos = 2'd0;
    logic [15:0] run_crc  = CRC_INIT;

    // Handshake bookkeeping
    bit item_taken = 1'b0;
    bit steady     = 1'b0;
    bit stall_req  = 1'b0;
    bit stall_done = 1'b0;
    int send_gap   = 0;
    int pop_gap    = 0;
    int hold_cnt   = 0;

    int errors      = 0;
    int items_sent  = 0;
    int bytes_out   = 0;
    int frames_out  = 0;
    int mark_writes = 0;

    slip_frame_encoder_crc16 dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Bitwise CRC-16, polynomial 0x1021, MSB first
    function automatic logic [15:0] crc16_fold(logic [15:0] c, logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
        return r;
    endfunction

    // Find the two-byte packet (unmarked) whose CRC equals the target
    function automatic logic [15:0] pair_for_crc(logic [15:0] target);
        logic [15:0] v;
        for (int n = 0; n < 65536; n++)
        begin
            v = n[15:0];
            if (crc16_fold(crc16_fold(CRC_INIT, v[15:8]), v[7:0]) == target)
                return v;
        end
        return 16'h0000;
    endfunction

    function automatic void put_byte(logic [7:0] b, logic fend);
        out_item_t r;
        r.out_byte  = b;
        r.run_last  = 1'b0;
        r.frame_end = fend;
        enc_due.push_back(r);
    endfunction

    function automatic void put_escaped(logic [7:0] b);
        if (b == END_CHAR)
        begin
            put_byte(ESC_CHAR, 1'b0);
            put_byte(ESC_END, 1'b0);
        end
        else if (b == ESC_CHAR)
        begin
            put_byte(ESC_CHAR, 1'b0);
            put_byte(ESC_ESC, 1'b0);
        end
        else
            put_byte(b, 1'b0);
    endfunction

    function automatic void encode_item(in_item_t it);
        logic [7:0] b;
        out_item_t  tail;
        b = it.data_byte;
        if (!pkt_open)
        begin
            put_byte(END_CHAR, 1'b0);
            pkt_open = 1'b1;
            byte_pos = 2'd0;
            run_crc  = CRC_INIT;
        end
        if (mark_en)
        begin
            if (byte_pos == 2'd0)
                b |= MARK_FIRST;
            else if (byte_pos == 2'd1)
                b |= MARK_SECOND;
        end
        if (byte_pos < POS_SAT)
            byte_pos++;
        run_crc = crc16_fold(run_crc, b);
        put_escaped(b);
        if (it.last_byte)
        begin
            put_escaped(run_crc[15:8]);
            put_escaped(run_crc[7:0]);
            put_byte(END_CHAR, 1'b1);
            pkt_open = 1'b0;
            byte_pos = 2'd0;
            run_crc  = CRC_INIT;
        end
        // flag the final byte this item causes
        tail = enc_due.pop_back();
        tail.run_last = 1'b1;
        enc_due.push_back(tail);
    endfunction

    // Sender: offer the head of the pending queue, with random gaps
    always @(negedge clk)
    begin
        if (item_taken)
            void'(tx_items.pop_front());
        if (send_gap > 0)
            send_gap--;
        else if (!steady && $urandom_range(0, 11) == 0)
            send_gap = $urandom_range(1, 8);
        if (tx_items.size() > 0 && send_gap == 0)
        begin
            push <= 1'b1;
            item <= tx_items[0];
        end
        else
            push <= 1'b0;
    end

    // Receiver: random pop gaps, plus one long hold when asked
    always @(negedge clk)
    begin
        if (stall_req && !stall_done)
        begin
            hold_cnt   = 60;
            stall_done = 1'b1;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            pop <= 1'b0;
        end
        else
        begin
            if (pop_gap > 0)
                pop_gap--;
            else if (!steady && $urandom_range(0, 9) == 0)
                pop_gap = $urandom_range(1, 8);
            pop <= (pop_gap == 0);
        end
    end

    // Monitor: predict on every accepted item, check every accepted result
    always @(posedge clk)
    begin
        out_item_t want;
        item_taken = rst_n && push && !full;
        if (item_taken)
        begin
            encode_item(item);
            items_sent++;
        end
        if (rst_n && pop && !empty)
        begin
            bytes_out++;
            if (result.frame_end)
                frames_out++;
            if (enc_due.size() == 0)
            begin
                $error("unexpected result: out_byte %0d", result.out_byte);
                errors++;
            end
            else
            begin
                want = enc_due.pop_front();
                if (result.out_byte !== want.out_byte)
                begin
                    $error("out_byte mismatch: expected %0d, got %0d",
                           want.out_byte, result.out_byte);
                    errors++;
                end
                if (result.run_last !== want.run_last)
                begin
                    $error("run_last mismatch: expected %0d, got %0d",
                           want.run_last, result.run_last);
                    errors++;
                end
                if (result.frame_end !== want.frame_end)
                begin
                    $error("frame_end mismatch: expected %0d, got %0d",
                           want.frame_end, result.frame_end);
                    errors++;
                end
            end
        end
    end

    task automatic queue_byte(logic [7:0] b, logic l);
        in_item_t it;
        it.data_byte = b;
        it.last_byte = l;
        tx_items.push_back(it);
    endtask

    // Packets of mostly short length; the phase may stop inside an open packet
    task automatic queue_packets(int count);
        int queued;
        int len;
        logic [7:0] b;
        queued = 0;
        while (queued < count)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            for (int i = 0; i < len && queued < count; i++)
            begin
                case ($urandom_range(0, 7))
                    0:       b = END_CHAR;
                    1:       b = ESC_CHAR;
                    2:       b = 8'h00;
                    3:       b = 8'hFF;
                    default: b = 8'($urandom_range(0, 255));
                endcase
                queue_byte(b, i == len - 1);
                queued++;
            end
        end
    endtask

    // Hold until every pending item is in and every owed byte is out
    task automatic wait_drained();
        do
            @(negedge clk);
        while (tx_items.size() != 0 || push || enc_due.size() != 0);
    endtask

    task automatic write_mark(logic v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        mark_en = v;
        mark_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [15:0] p;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Marking on from reset: one-byte packets, then marks, escapes, saturation
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(END_CHAR, 1'b0);
        queue_byte(ESC_CHAR, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_drained();

        // Marking off: raw escapes and CRC trailers that need escaping
        write_mark(1'b0);
        queue_byte(END_CHAR, 1'b1);
        queue_byte(ESC_CHAR, 1'b1);
        p = pair_for_crc({END_CHAR, ESC_CHAR});
        queue_byte(p[15:8], 1'b0);
        queue_byte(p[7:0], 1'b1);
        p = pair_for_crc({ESC_CHAR, END_CHAR});
        queue_byte(p[15:8], 1'b0);
        queue_byte(p[7:0], 1'b1);
        queue_byte(8'h5A, 1'b0);
        wait_drained();

        // Switch marking on with a packet open: the second byte takes the mark
        write_mark(1'b1);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'hFF, 1'b1);
        wait_drained();

        queue_packets(80);
        wait_drained();

        // Long result stall while the sender keeps offering
        write_mark(1'($urandom_range(0, 1)));
        queue_packets(80);
        stall_req = 1'b1;
        wait_drained();

        write_mark(1'b0);
        queue_packets(80);
        wait_drained();

        write_mark(1'b1);
        steady = 1'b1;
        queue_packets(90);
        wait_drained();

        // let any stray result show up
        repeat (20) @(posedge clk);

        $display("covered %0d items, %0d frames, %0d frame bytes checked", items_sent,
                 frames_out, bytes_out);
        $display("header mark written %0d times, one 60-cycle result stall", mark_writes);
        if (errors == 0)
            $display("slip_frame_encoder_crc16 regression: pass");
        else
            $display("slip_frame_encoder_crc16 regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("slip_frame_encoder_crc16 regression: fail");
        $finish;
    end

endmodule
